/* rtl/atapio_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// atapio_pkg
// Shared types, register defaults and codes for the ATA PIO read sequencer.
// ---------------------------------------------------------------------------
package atapio_pkg;

    // widths fixed by the bus and the task file
    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 16;
    localparam int LBA_W    = 48;
    localparam int CNT_W    = 16;
    localparam int POS_W    = 23;
    localparam int LBA28_W  = 28;
    localparam int CFG_IDX_W = 3;

    // defaults for top level parameters
    localparam int DELAY_READS_DEF = 4;
    localparam int QUEUE_DEPTH_DEF = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TF_BASE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CB_BASE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DRIVE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEV_SECT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WPS      = 3'd4;

    // register reset values
    localparam logic [ADDR_W-1:0] TF_BASE_RST  = 16'h01F0;
    localparam logic [ADDR_W-1:0] CB_BASE_RST  = 16'h03F6;
    localparam logic [LBA_W-1:0]  DEV_SECT_RST = '0;
    localparam logic [15:0]       WPS_RST      = 16'd256;

    // result kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WORD  = 2'd2;
    localparam logic [1:0] KIND_DONE  = 2'd3;

    // completion codes
    localparam logic [2:0] OUT_OK        = 3'd0;
    localparam logic [2:0] OUT_LBA_LIMIT = 3'd1;
    localparam logic [2:0] OUT_COUNT     = 3'd2;
    localparam logic [2:0] OUT_DEVICE    = 3'd3;
    localparam logic [2:0] OUT_DEV_ERR   = 3'd4;

    // task file register offsets
    localparam logic [ADDR_W-1:0] TF_DATA    = 16'd0;
    localparam logic [ADDR_W-1:0] TF_COUNT   = 16'd2;
    localparam logic [ADDR_W-1:0] TF_LBA_LO  = 16'd3;
    localparam logic [ADDR_W-1:0] TF_LBA_MID = 16'd4;
    localparam logic [ADDR_W-1:0] TF_LBA_HI  = 16'd5;
    localparam logic [ADDR_W-1:0] TF_DRIVE   = 16'd6;
    localparam logic [ADDR_W-1:0] TF_CMD     = 16'd7;

    localparam logic [7:0] DEV_HEAD_BASE = 8'hE0;
    localparam logic [7:0] CMD_READ_SECT = 8'h20;
    localparam logic [7:0] MAX_COUNT     = 8'hFF;
    localparam logic [LBA_W:0] LBA28_LIMIT = 49'(1) << LBA28_W;

    // status bits
    localparam int ST_BSY = 7;
    localparam int ST_DRQ = 3;
    localparam int ST_ERR = 0;

    // input channel codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_RESP  = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [LBA_W-1:0]  start_lba;
        logic [CNT_W-1:0]  sector_total;
        logic [DATA_W-1:0] read_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] bus_address;
        logic [DATA_W-1:0] payload;
        logic [POS_W-1:0]  word_position;
        logic [2:0]        outcome;
        logic              final_res;
    } out_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] task_file_base;
        logic [ADDR_W-1:0] control_block_base;
        logic              drive_select;
        logic [LBA_W-1:0]  device_sectors;
        logic [15:0]       sector_words;
    } cfg_t;

    // work orders handed from the front to the back
    typedef enum logic [3:0] {
        JOB_DONE,
        JOB_START,
        JOB_DELAY,
        JOB_TASK,
        JOB_STAT,
        JOB_DATA,
        JOB_WORD_DATA,
        JOB_WORD_STAT,
        JOB_WORD_DONE
    } job_op_t;

    typedef struct packed {
        job_op_t            op;
        logic [2:0]         outcome;
        logic [7:0]         count;
        logic [LBA28_W-1:0] lba;
        logic [DATA_W-1:0]  value;
        logic [POS_W-1:0]   position;
    } job_t;

endpackage

/* rtl/ata_pio_read_sequencer_top.sv */
`timescale 1ns / 1ps
// the path of a taken word: job queue, then the back end's current job register, then the
// output register, from which its first result shows on m_
// throughput: one word taken per cycle while the job queue has room; one result per cycle
// out while the receiver is ready; a word causes 0 to 6 results
// reset: synchronous active low; clears transfer state, queue and output valid, and
// loads the register defaults; no clearing pass
// ---------------------------------------------------------------------------
// ata_pio_read_sequencer_top
// ATA PIO READ SECTORS sequencer with 28-bit LBA: front checks and steps the
// transfer, a job queue decouples it from the back end that emits results.
// ---------------------------------------------------------------------------
module ata_pio_read_sequencer_top #(
    parameter int DELAY_READS = atapio_pkg::DELAY_READS_DEF,
    parameter int QUEUE_DEPTH = atapio_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [atapio_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [atapio_pkg::LBA_W-1:0]        cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  atapio_pkg::in_item_t                s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output atapio_pkg::out_item_t               m_data
);

    atapio_pkg::cfg_t cfg_reg, cfg_next;
    atapio_pkg::job_t push_job;
    atapio_pkg::job_t head_job;
    logic             job_push;
    logic             q_pop;
    logic             q_empty;
    logic             q_full;
    logic             take;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                atapio_pkg::CFG_IDX_TF_BASE:  cfg_next.task_file_base     = cfg_wdata[15:0];
                atapio_pkg::CFG_IDX_CB_BASE:  cfg_next.control_block_base = cfg_wdata[15:0];
                atapio_pkg::CFG_IDX_DRIVE:    cfg_next.drive_select       = cfg_wdata[0];
                atapio_pkg::CFG_IDX_DEV_SECT: cfg_next.device_sectors     = cfg_wdata;
                atapio_pkg::CFG_IDX_WPS:      cfg_next.sector_words       = cfg_wdata[15:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.task_file_base     <= atapio_pkg::TF_BASE_RST;
            cfg_reg.control_block_base <= atapio_pkg::CB_BASE_RST;
            cfg_reg.drive_select       <= 1'b0;
            cfg_reg.device_sectors     <= atapio_pkg::DEV_SECT_RST;
            cfg_reg.sector_words       <= atapio_pkg::WPS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_ready = !q_full;
    assign take    = s_valid && s_ready;

    atapio_front #(
        .DELAY_READS (DELAY_READS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .take     (take),
        .item     (s_data),
        .job_push (job_push),
        .job      (push_job)
    );

    atapio_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    atapio_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .head_job (head_job),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // a completion always closes the results of its word
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.kind == atapio_pkg::KIND_DONE) |-> m_data.final_res)
        else $error("done result without final mark");

    // a delivered data word is always followed by another result of the same word
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.kind == atapio_pkg::KIND_WORD) |-> !m_data.final_res)
        else $error("data word marked final");

    // nothing is popped from an empty queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("job queue underflow");

    // output stage is empty right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

/* rtl/atapio_fifo.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// atapio_fifo
// Short job queue between the classifying front and the result back end.
// ---------------------------------------------------------------------------
module atapio_fifo #(
    parameter int DEPTH = atapio_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  atapio_pkg::job_t  push_job,
    input  logic              pop,
    output atapio_pkg::job_t  head_job,
    output logic              empty,
    output logic              full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    atapio_pkg::job_t mem_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign head_job = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* rtl/atapio_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// atapio_front
// Takes requests and bus responses, checks them, steps the transfer state
// and queues one job per word that needs results.
// ---------------------------------------------------------------------------
module atapio_front #(
    parameter int DELAY_READS = atapio_pkg::DELAY_READS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  atapio_pkg::cfg_t     cfg,
    input  logic                 take,
    input  atapio_pkg::in_item_t item,
    output logic                 job_push,
    output atapio_pkg::job_t     job
);

    localparam int DLY_W = $clog2(DELAY_READS + 1);
    localparam logic [DLY_W-1:0] DLY_LOAD = DLY_W'(DELAY_READS - 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DELAY,
        PH_POLL,
        PH_DATA
    } phase_t;

    phase_t                         phase_reg, phase_next;
    logic [DLY_W-1:0]               delay_left_reg, delay_left_next;
    logic [atapio_pkg::LBA28_W-1:0] lba_reg, lba_next;
    logic [7:0]                     sectors_left_reg, sectors_left_next;
    logic [15:0]                    words_left_reg, words_left_next;
    logic [atapio_pkg::POS_W-1:0]   position_reg, position_next;

    logic [atapio_pkg::LBA_W:0]     span;
    logic [7:0]                     status;
    logic [15:0]                    words_dec;
    logic [7:0]                     sectors_dec;

    assign span        = {1'b0, item.start_lba} + (atapio_pkg::LBA_W + 1)'(item.sector_total);
    assign status      = item.read_value[7:0];
    assign words_dec   = words_left_reg - 1'b1;
    assign sectors_dec = sectors_left_reg - 1'b1;

    always_comb begin
        phase_next        = phase_reg;
        delay_left_next   = delay_left_reg;
        lba_next          = lba_reg;
        sectors_left_next = sectors_left_reg;
        words_left_next   = words_left_reg;
        position_next     = position_reg;
        job_push          = 1'b0;
        job.op            = atapio_pkg::JOB_DONE;
        job.outcome       = atapio_pkg::OUT_OK;
        job.count         = sectors_left_reg;
        job.lba           = lba_reg;
        job.value         = item.read_value;
        job.position      = position_reg;

        if (take) begin
            if (item.cmd == atapio_pkg::CMD_START) begin
                if (phase_reg == PH_IDLE) begin
                    job_push = 1'b1;
                    if (span > atapio_pkg::LBA28_LIMIT) begin
                        job.outcome = atapio_pkg::OUT_LBA_LIMIT;
                    end else if (item.sector_total > 16'(atapio_pkg::MAX_COUNT)) begin
                        job.outcome = atapio_pkg::OUT_COUNT;
                    end else if (span > {1'b0, cfg.device_sectors}) begin
                        job.outcome = atapio_pkg::OUT_DEVICE;
                    end else if (item.sector_total != '0) begin
                        job.op            = atapio_pkg::JOB_START;
                        job.lba           = item.start_lba[atapio_pkg::LBA28_W-1:0];
                        lba_next          = item.start_lba[atapio_pkg::LBA28_W-1:0];
                        sectors_left_next = item.sector_total[7:0];
                        position_next     = '0;
                        delay_left_next   = DLY_LOAD;
                        phase_next        = PH_DELAY;
                    end
                end
            end else begin
                case (phase_reg)
                    PH_DELAY: begin
                        job_push = 1'b1;
                        if (delay_left_reg != '0) begin
                            delay_left_next = delay_left_reg - 1'b1;
                            job.op          = atapio_pkg::JOB_DELAY;
                        end else begin
                            job.op     = atapio_pkg::JOB_TASK;
                            phase_next = PH_POLL;
                        end
                    end
                    PH_POLL: begin
                        job_push = 1'b1;
                        if (status[atapio_pkg::ST_BSY] ||
                            !(status[atapio_pkg::ST_DRQ] || status[atapio_pkg::ST_ERR])) begin
                            job.op = atapio_pkg::JOB_STAT;
                        end else if (status[atapio_pkg::ST_ERR]) begin
                            job.outcome = atapio_pkg::OUT_DEV_ERR;
                            phase_next  = PH_IDLE;
                        end else begin
                            // zero words per sector behaves as one
                            words_left_next = (cfg.sector_words != '0) ?
                                              cfg.sector_words : 16'd1;
                            job.op          = atapio_pkg::JOB_DATA;
                            phase_next      = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        job_push        = 1'b1;
                        position_next   = position_reg + 1'b1;
                        words_left_next = words_dec;
                        if (words_dec != '0) begin
                            job.op = atapio_pkg::JOB_WORD_DATA;
                        end else begin
                            sectors_left_next = sectors_dec;
                            if (sectors_dec != '0) begin
                                job.op     = atapio_pkg::JOB_WORD_STAT;
                                phase_next = PH_POLL;
                            end else begin
                                job.op     = atapio_pkg::JOB_WORD_DONE;
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                    default: begin
                        job_push = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            delay_left_reg   <= '0;
            lba_reg          <= '0;
            sectors_left_reg <= '0;
            words_left_reg   <= '0;
            position_reg     <= '0;
        end else begin
            phase_reg        <= phase_next;
            delay_left_reg   <= delay_left_next;
            lba_reg          <= lba_next;
            sectors_left_reg <= sectors_left_next;
            words_left_reg   <= words_left_next;
            position_reg     <= position_next;
        end
    end

endmodule

/* rtl/atapio_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// atapio_back
// Expands queued jobs into bus accesses, data words and completions, one
// result per cycle into the output register while that register is free.
// ---------------------------------------------------------------------------
module atapio_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  atapio_pkg::cfg_t      cfg,
    input  atapio_pkg::job_t      head_job,
    input  logic                  q_empty,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output atapio_pkg::out_item_t m_data
);

    atapio_pkg::job_t      cur_reg, cur_next;
    logic                  cur_valid_reg, cur_valid_next;
    logic [2:0]            step_reg, step_next;
    logic                  m_valid_reg, m_valid_next;
    atapio_pkg::out_item_t m_data_reg, m_data_next;

    logic                  out_free;
    logic                  emit;
    logic                  last;
    logic [2:0]            last_step;
    atapio_pkg::out_item_t res;

    function automatic logic [2:0] job_last_step(atapio_pkg::job_op_t op);
        logic [2:0] s;
        case (op)
            atapio_pkg::JOB_START:     s = 3'd1;
            atapio_pkg::JOB_TASK:      s = 3'd5;
            atapio_pkg::JOB_WORD_DATA: s = 3'd1;
            atapio_pkg::JOB_WORD_STAT: s = 3'd1;
            atapio_pkg::JOB_WORD_DONE: s = 3'd1;
            default:                   s = 3'd0;
        endcase
        return s;
    endfunction

    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = cur_valid_reg && out_free;
    assign last_step = job_last_step(cur_reg.op);
    assign last      = (step_reg == last_step);
    assign q_pop     = !q_empty && (!cur_valid_reg || (emit && last));

    always_comb begin
        res               = '0;
        res.final_res     = last;
        case (cur_reg.op)
            atapio_pkg::JOB_DONE: begin
                res.kind    = atapio_pkg::KIND_DONE;
                res.outcome = cur_reg.outcome;
            end
            atapio_pkg::JOB_START: begin
                if (step_reg == 3'd0) begin
                    res.kind        = atapio_pkg::KIND_WRITE;
                    res.bus_address = cfg.task_file_base + atapio_pkg::TF_DRIVE;
                    res.payload     = {8'h00, atapio_pkg::DEV_HEAD_BASE |
                                       {3'b000, cfg.drive_select, cur_reg.lba[27:24]}};
                end else begin
                    res.kind        = atapio_pkg::KIND_READ;
                    res.bus_address = cfg.control_block_base;
                end
            end
            atapio_pkg::JOB_DELAY: begin
                res.kind        = atapio_pkg::KIND_READ;
                res.bus_address = cfg.control_block_base;
            end
            atapio_pkg::JOB_TASK: begin
                res.kind = atapio_pkg::KIND_WRITE;
                case (step_reg)
                    3'd0: begin
                        res.bus_address = cfg.task_file_base + atapio_pkg::TF_COUNT;
                        res.payload     = {8'h00, cur_reg.count};
                    end
                    3'd1: begin
                        res.bus_address = cfg.task_file_base + atapio_pkg::TF_LBA_LO;
                        res.payload     = {8'h00, cur_reg.lba[7:0]};
                    end
                    3'd2: begin
                        res.bus_address = cfg.task_file_base + atapio_pkg::TF_LBA_MID;
                        res.payload     = {8'h00, cur_reg.lba[15:8]};
                    end
                    3'd3: begin
                        res.bus_address = cfg.task_file_base + atapio_pkg::TF_LBA_HI;
                        res.payload     = {8'h00, cur_reg.lba[23:16]};
                    end
                    3'd4: begin
                        res.bus_address = cfg.task_file_base + atapio_pkg::TF_CMD;
                        res.payload     = {8'h00, atapio_pkg::CMD_READ_SECT};
                    end
                    default: begin
                        // first status poll after the command
                        res.kind        = atapio_pkg::KIND_READ;
                        res.bus_address = cfg.task_file_base + atapio_pkg::TF_CMD;
                    end
                endcase
            end
            atapio_pkg::JOB_STAT: begin
                res.kind        = atapio_pkg::KIND_READ;
                res.bus_address = cfg.task_file_base + atapio_pkg::TF_CMD;
            end
            atapio_pkg::JOB_DATA: begin
                res.kind        = atapio_pkg::KIND_READ;
                res.bus_address = cfg.task_file_base + atapio_pkg::TF_DATA;
            end
            default: begin
                // word delivery followed by the next access or completion
                if (step_reg == 3'd0) begin
                    res.kind          = atapio_pkg::KIND_WORD;
                    res.payload       = cur_reg.value;
                    res.word_position = cur_reg.position;
                end else if (cur_reg.op == atapio_pkg::JOB_WORD_DATA) begin
                    res.kind        = atapio_pkg::KIND_READ;
                    res.bus_address = cfg.task_file_base + atapio_pkg::TF_DATA;
                end else if (cur_reg.op == atapio_pkg::JOB_WORD_STAT) begin
                    res.kind        = atapio_pkg::KIND_READ;
                    res.bus_address = cfg.task_file_base + atapio_pkg::TF_CMD;
                end else begin
                    res.kind    = atapio_pkg::KIND_DONE;
                    res.outcome = atapio_pkg::OUT_OK;
                end
            end
        endcase
    end

    always_comb begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        step_next      = step_reg;
        if (q_pop) begin
            cur_next       = head_job;
            cur_valid_next = 1'b1;
            step_next      = '0;
        end else if (emit && last) begin
            cur_valid_next = 1'b0;
        end else if (emit) begin
            step_next = step_reg + 1'b1;
        end

        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_data_next  = res;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            step_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            step_reg      <= step_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Checks the ATA PIO read sequencer result for result against a cycle-free
// model of the transfer. Covers the request checks, delay reads, status
// polling with retries and errors, data delivery, dropped words, extreme
// register settings, a long receiver stall and random traffic.
// ---------------------------------------------------------------------------
module tb;
    import atapio_pkg::*;

    localparam int DELAY_READS   = DELAY_READS_DEF;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int RAND_ITEMS    = 72;

    typedef enum logic [1:0] {SEQ_IDLE, SEQ_DELAY, SEQ_POLL, SEQ_DATA} seq_state_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LBA_W-1:0]     cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    in_item_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    out_item_t            m_data;

    ata_pio_read_sequencer_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // register copy and transfer state of the sequencer model
    cfg_t               regs;
    seq_state_t         seq_state;
    int                 delay_left;
    logic [LBA28_W-1:0] lba_latched;
    logic [7:0]         sectors_left;
    logic [15:0]        words_left;
    logic [POS_W-1:0]   next_pos;

    out_item_t bus_ops_q[$];
    out_item_t held;
    bit        held_ok;
    int        emitted;

    int errors = 0;
    int stall_count = 0;
    int hold_req = 0;
    bit src_idle = 1'b1;
    bit snk_idle = 1'b1;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------- sequencer model ----------------

    function automatic void emit(input logic [1:0] kind, input logic [ADDR_W-1:0] addr,
                                 input logic [DATA_W-1:0] pay, input logic [POS_W-1:0] pos,
                                 input logic [2:0] oc);
        if (held_ok)
            bus_ops_q.push_back(held);
        held.kind          = kind;
        held.bus_address   = addr;
        held.payload       = pay;
        held.word_position = pos;
        held.outcome       = oc;
        held.final_res     = 1'b0;
        held_ok = 1'b1;
        emitted++;
    endfunction

    function automatic void finish_with(input logic [2:0] oc);
        emit(KIND_DONE, '0, '0, '0, oc);
        seq_state = SEQ_IDLE;
    endfunction

    function automatic void status_read();
        emit(KIND_READ, regs.task_file_base + TF_CMD, '0, '0, OUT_OK);
    endfunction

    function automatic void predict(input in_item_t w);
        logic [LBA_W:0] sum;
        logic [LBA_W:0] cnt_ext;
        logic [7:0]     st;
        emitted = 0;
        if (w.cmd == CMD_START) begin
            if (seq_state == SEQ_IDLE) begin
                cnt_ext = (LBA_W + 1)'(w.sector_total);
                sum = {1'b0, w.start_lba} + cnt_ext;
                if (sum > LBA28_LIMIT) begin
                    finish_with(OUT_LBA_LIMIT);
                end else if (w.sector_total > CNT_W'(MAX_COUNT)) begin
                    finish_with(OUT_COUNT);
                end else if (sum > {1'b0, regs.device_sectors}) begin
                    finish_with(OUT_DEVICE);
                end else if (w.sector_total == '0) begin
                    // a zero count byte would mean 256 to the drive
                    finish_with(OUT_OK);
                end else begin
                    lba_latched  = w.start_lba[LBA28_W-1:0];
                    sectors_left = w.sector_total[7:0];
                    next_pos     = '0;
                    emit(KIND_WRITE, regs.task_file_base + TF_DRIVE,
                         {8'h00, DEV_HEAD_BASE |
                          {3'b000, regs.drive_select, lba_latched[27:24]}},
                         '0, OUT_OK);
                    emit(KIND_READ, regs.control_block_base, '0, '0, OUT_OK);
                    delay_left = (DELAY_READS > 1) ? DELAY_READS - 1 : 0;
                    seq_state  = SEQ_DELAY;
                end
            end
        end else begin
            st = w.read_value[7:0];
            case (seq_state)
                SEQ_DELAY: begin
                    if (delay_left > 0) begin
                        delay_left--;
                        emit(KIND_READ, regs.control_block_base, '0, '0, OUT_OK);
                    end else begin
                        emit(KIND_WRITE, regs.task_file_base + TF_COUNT,
                             {8'h00, sectors_left}, '0, OUT_OK);
                        emit(KIND_WRITE, regs.task_file_base + TF_LBA_LO,
                             {8'h00, lba_latched[7:0]}, '0, OUT_OK);
                        emit(KIND_WRITE, regs.task_file_base + TF_LBA_MID,
                             {8'h00, lba_latched[15:8]}, '0, OUT_OK);
                        emit(KIND_WRITE, regs.task_file_base + TF_LBA_HI,
                             {8'h00, lba_latched[23:16]}, '0, OUT_OK);
                        emit(KIND_WRITE, regs.task_file_base + TF_CMD,
                             {8'h00, CMD_READ_SECT}, '0, OUT_OK);
                        status_read();
                        seq_state = SEQ_POLL;
                    end
                end
                SEQ_POLL: begin
                    if (st[ST_BSY] || !(st[ST_DRQ] || st[ST_ERR])) begin
                        status_read();
                    end else if (st[ST_ERR]) begin
                        finish_with(OUT_DEV_ERR);
                    end else begin
                        words_left = (regs.sector_words == '0) ? 16'd1
                                                                : regs.sector_words;
                        emit(KIND_READ, regs.task_file_base + TF_DATA, '0, '0, OUT_OK);
                        seq_state = SEQ_DATA;
                    end
                end
                SEQ_DATA: begin
                    emit(KIND_WORD, '0, w.read_value, next_pos, OUT_OK);
                    next_pos++;
                    words_left--;
                    if (words_left != '0) begin
                        emit(KIND_READ, regs.task_file_base + TF_DATA, '0, '0, OUT_OK);
                    end else begin
                        sectors_left--;
                        if (sectors_left != '0) begin
                            status_read();
                            seq_state = SEQ_POLL;
                        end else begin
                            finish_with(OUT_OK);
                        end
                    end
                end
                default: ;
            endcase
        end
        if (held_ok) begin
            held.final_res = 1'b1;
            bus_ops_q.push_back(held);
            held_ok = 1'b0;
        end
    endfunction

    // ---------------- word builders ----------------

    function automatic logic [LBA_W-1:0] rand_lba48();
        return LBA_W'({$urandom, $urandom});
    endfunction

    function automatic in_item_t start_word(input logic [LBA_W-1:0] lba,
                                            input logic [CNT_W-1:0] cnt);
        in_item_t w;
        w.cmd          = CMD_START;
        w.start_lba    = lba;
        w.sector_total = cnt;
        w.read_value   = 16'($urandom);
        return w;
    endfunction

    function automatic in_item_t resp_word(input logic [DATA_W-1:0] v);
        in_item_t w;
        w.cmd          = CMD_RESP;
        w.start_lba    = rand_lba48();
        w.sector_total = 16'($urandom);
        w.read_value   = v;
        return w;
    endfunction

    // mostly data ready, some busy or empty polls, a few errors
    function automatic logic [DATA_W-1:0] poll_status();
        logic [DATA_W-1:0] v;
        int sel;
        v   = 16'($urandom);
        sel = $urandom_range(0, 9);
        if (sel <= 5) begin
            v[ST_BSY] = 1'b0;
            v[ST_ERR] = 1'b0;
            v[ST_DRQ] = 1'b1;
        end else if (sel <= 7) begin
            v[ST_BSY] = 1'b1;
        end else if (sel == 8) begin
            v[ST_BSY] = 1'b0;
            v[ST_DRQ] = 1'b0;
            v[ST_ERR] = 1'b0;
        end else begin
            v[ST_BSY] = 1'b0;
            v[ST_ERR] = 1'b1;
        end
        return v;
    endfunction

    // ---------------- driving ----------------

    task automatic send_word(input in_item_t w);
        int gap;
        gap = src_idle ? $urandom_range(0, 10) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict(w);
    endtask

    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (bus_ops_q.size() != 0)
            @(posedge aclk);
        // dropped words leave no result behind
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LBA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_IDX_TF_BASE:  regs.task_file_base     = val[ADDR_W-1:0];
            CFG_IDX_CB_BASE:  regs.control_block_base = val[ADDR_W-1:0];
            CFG_IDX_DRIVE:    regs.drive_select       = val[0];
            CFG_IDX_DEV_SECT: regs.device_sectors     = val;
            CFG_IDX_WPS:      regs.sector_words       = val[15:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_regs(input logic [ADDR_W-1:0] tf, input logic [ADDR_W-1:0] cb,
                            input logic drv, input logic [LBA_W-1:0] dev,
                            input logic [15:0] wps);
        write_reg(CFG_IDX_TF_BASE, LBA_W'(tf));
        write_reg(CFG_IDX_CB_BASE, LBA_W'(cb));
        write_reg(CFG_IDX_DRIVE, LBA_W'(drv));
        write_reg(CFG_IDX_DEV_SECT, dev);
        write_reg(CFG_IDX_WPS, LBA_W'(wps));
    endtask

    // answer bus reads until the transfer ends, by error or by reading it out
    task automatic respond_until_idle(input bit fail_polls);
        logic [DATA_W-1:0] v;
        while (seq_state != SEQ_IDLE) begin
            v = 16'($urandom);
            if (seq_state == SEQ_POLL) begin
                v[ST_BSY] = 1'b0;
                v[ST_ERR] = fail_polls;
                v[ST_DRQ] = 1'b1;
            end
            send_word(resp_word(v));
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_defaults();
        send_word(start_word('0, '0));
        send_word(start_word('0, 16'd1));
        send_word(start_word('1, '1));
        send_word(resp_word(16'hFFFF));
        settle();
    endtask

    task automatic test_request_checks();
        set_regs(TF_BASE_RST, CB_BASE_RST, 1'b0, '1, 16'd1);
        // last sector below the 28-bit limit is still legal
        send_word(start_word(LBA_W'(28'hFFFFFFF), 16'd1));
        respond_until_idle(1'b1);
        send_word(start_word(LBA_W'(1 << 28), '0));
        send_word(start_word(LBA_W'((1 << 28) - 10), 16'd300));
        send_word(start_word('0, 16'd256));
        send_word(start_word('0, 16'hFFFF));
        settle();
        write_reg(CFG_IDX_DEV_SECT, 48'd100);
        send_word(start_word(48'd90, 16'd11));
        send_word(start_word(48'd90, 16'd10));
        respond_until_idle(1'b1);
        settle();
    endtask

    task automatic test_directed_read();
        set_regs(16'hFFFC, 16'hFFFF, 1'b1, '1, 16'd0);
        send_word(start_word(48'h0000_0ABC_DEF1, 16'd2));
        send_word(start_word('0, 16'd1));
        send_word(resp_word(16'hFFFF));
        send_word(resp_word(16'h0000));
        send_word(resp_word(16'($urandom)));
        send_word(resp_word(16'($urandom)));
        send_word(resp_word(16'h0088));
        send_word(resp_word(16'hFF00));
        send_word(resp_word(16'h0008));
        send_word(resp_word(16'hFFFF));
        send_word(resp_word(16'h0081));
        // error wins over data request
        send_word(resp_word(16'h0009));
        send_word(resp_word(16'h1234));
        settle();
        write_reg(CFG_IDX_WPS, 48'd2);
        send_word(start_word(48'd5, 16'd1));
        respond_until_idle(1'b0);
        settle();
    endtask

    task automatic test_full_count();
        set_regs(TF_BASE_RST, CB_BASE_RST, 1'b0, '1, 16'd1);
        send_word(start_word(48'd1000, 16'd255));
        respond_until_idle(1'b1);
        settle();
    endtask

    task automatic test_long_sector();
        write_reg(CFG_IDX_WPS, 48'd40);
        src_idle = 1'b0;
        snk_idle = 1'b0;
        send_word(start_word(48'd7, 16'd1));
        respond_until_idle(1'b0);
        settle();
        src_idle = 1'b1;
        snk_idle = 1'b1;
    endtask

    task automatic test_backpressure();
        write_reg(CFG_IDX_WPS, 48'd8);
        src_idle = 1'b0;
        hold_req = HOLD_CYCLES;
        send_word(start_word('0, 16'd4));
        respond_until_idle(1'b0);
        settle();
        src_idle = 1'b1;
    endtask

    task automatic test_random();
        int p;
        int count;
        int r;
        int unsigned span;
        logic [LBA_W-1:0] dev;
        logic [CNT_W-1:0] cnt;
        in_item_t w;
        for (p = 0; p < 4; p++) begin
            span = (1 << 28) - 1;
            case (p)
                0: begin
                    set_regs(16'($urandom), 16'($urandom), 1'b0, '1, 16'd1);
                    src_idle = 1'b1;
                    snk_idle = 1'b1;
                end
                1: begin
                    set_regs(16'hFFFF, 16'h0000, 1'b1, LBA_W'(1 << 28), 16'd0);
                    src_idle = 1'b0;
                    snk_idle = 1'b1;
                end
                2: begin
                    dev = LBA_W'($urandom_range(16, 4096));
                    set_regs(16'h0000, 16'hFFFF, 1'($urandom), dev,
                             16'($urandom_range(2, 6)));
                    span = 32'(dev) + 8;
                    src_idle = 1'b1;
                    snk_idle = 1'b0;
                end
                default: begin
                    set_regs(16'($urandom), 16'($urandom), 1'($urandom), rand_lba48(),
                             16'($urandom_range(1, 4)));
                    src_idle = 1'b1;
                    snk_idle = 1'b1;
                end
            endcase
            count = 0;
            while (count < RAND_ITEMS) begin
                r = $urandom_range(0, 99);
                if (seq_state == SEQ_IDLE) begin
                    if (r < 70) begin
                        cnt = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(1, 3))
                                                          : 16'($urandom_range(4, 12));
                        w = start_word(LBA_W'($urandom_range(0, span)), cnt);
                    end else if (r < 85) begin
                        w = start_word(rand_lba48(), 16'($urandom));
                    end else if (r < 92) begin
                        w = start_word(LBA_W'($urandom_range(0, 1 << 28)),
                                       16'($urandom_range(0, 300)));
                    end else begin
                        w = resp_word(16'($urandom));
                    end
                end else if (r < 6) begin
                    w = start_word(rand_lba48(), 16'($urandom));
                end else if (seq_state == SEQ_POLL) begin
                    w = resp_word(poll_status());
                end else begin
                    w = resp_word(16'($urandom));
                end
                send_word(w);
                if (emitted > 0)
                    count++;
            end
            respond_until_idle(1'b1);
            settle();
        end
        src_idle = 1'b1;
        snk_idle = 1'b1;
    endtask

    // ---------------- main sequence ----------------

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        regs.task_file_base     = TF_BASE_RST;
        regs.control_block_base = CB_BASE_RST;
        regs.drive_select       = 1'b0;
        regs.device_sectors     = DEV_SECT_RST;
        regs.sector_words       = WPS_RST;
        seq_state    = SEQ_IDLE;
        delay_left   = 0;
        lba_latched  = '0;
        sectors_left = '0;
        words_left   = '0;
        next_pos     = '0;
        held_ok      = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_defaults();
        test_request_checks();
        test_directed_read();
        test_full_count();
        test_long_sector();
        test_backpressure();
        test_random();

        settle();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // result side ready, with random stalls and the occasional long hold
    initial begin
        int stall;
        m_ready = 1'b0;
        forever begin
            if (hold_req > 0) begin
                stall    = hold_req;
                hold_req = 0;
            end else begin
                stall = snk_idle ? $urandom_range(0, 10) : 0;
            end
            repeat (stall) begin
                @(negedge aclk);
                m_ready <= 1'b0;
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid === 1'b1 && aresetn === 1'b1));
        end
    end

    function automatic void check_field(input string name, input logic [POS_W-1:0] want,
                                        input logic [POS_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (bus_ops_q.size() == 0) begin
                $error("result with nothing expected: %h", m_data);
                errors++;
            end else begin
                want = bus_ops_q.pop_front();
                check_field("kind", POS_W'(want.kind), POS_W'(m_data.kind));
                check_field("bus_address", POS_W'(want.bus_address),
                            POS_W'(m_data.bus_address));
                check_field("payload", POS_W'(want.payload), POS_W'(m_data.payload));
                check_field("word_position", want.word_position, m_data.word_position);
                check_field("outcome", POS_W'(want.outcome), POS_W'(m_data.outcome));
                check_field("final_res", POS_W'(want.final_res), POS_W'(m_data.final_res));
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge aclk) begin
        if ((s_valid === 1'b1 && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready === 1'b1)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

endmodule
